### hdl/mkced_pkg.sv
package mkced_pkg;

    // Build-time sizes
    localparam int NUM_KEYS      = 8;
    localparam int SAMPLE_DIVIDE = 20;
    localparam int TIMER_BITS    = 16;
    localparam int PIN_BITS      = 8;
    localparam int PRESC_W       = $clog2(SAMPLE_DIVIDE + 1);

    // Field widths
    localparam int FLAG_W   = 7;
    localparam int THR_W    = 16;
    localparam int KCNT_W   = 4;
    localparam int KIDX_W   = 3;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 16;

    // Flag bit positions
    localparam int FB_HOLD   = 0;
    localparam int FB_DOWN   = 1;
    localparam int FB_UP     = 2;
    localparam int FB_SINGLE = 3;
    localparam int FB_DOUBLE = 4;
    localparam int FB_LONG   = 5;
    localparam int FB_REPEAT = 6;

    localparam logic [FLAG_W-1:0] F_HOLD = FLAG_W'(1) << FB_HOLD;

    // Action codes
    localparam logic ACT_TICK  = 1'b0;
    localparam logic ACT_CHECK = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_TICKS   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_TICKS = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_TICKS = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_COUNT    = CFG_IDX_W'(3);

    typedef struct packed {
        logic              action;
        logic [7:0]        pin_levels;
        logic [KIDX_W-1:0] key_index;
        logic [FLAG_W-1:0] flag_mask;
    } t_in_item;

    typedef struct packed {
        logic              event_hit;
        logic [FLAG_W-1:0] key_flags;
    } t_out_item;

    // Per-key control from the item stage
    typedef struct packed {
        logic              tick;
        logic              sample;
        logic              pressed;
        logic              clr;
        logic [FLAG_W-1:0] clr_mask;
    } t_key_ctl;

    // Thresholds as loaded into the key timers
    typedef struct packed {
        logic [TIMER_BITS-1:0] long_ticks;
        logic [TIMER_BITS-1:0] double_ticks;
        logic [TIMER_BITS-1:0] repeat_ticks;
    } t_thr;

endpackage

### hdl/mkced_key.sv
module mkced_key (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  mkced_pkg::t_key_ctl               i_ctl,
    input  mkced_pkg::t_thr                   i_thr,
    output logic [mkced_pkg::FLAG_W-1:0]      o_flags
);
    import mkced_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_PRESSED = 3'd1,
        PH_RELEASE = 3'd2,
        PH_DOUBLE  = 3'd3,
        PH_LONG    = 3'd4
    } t_phase;

    t_phase                r_ph, n_ph;
    logic                  r_last, n_last;
    logic [TIMER_BITS-1:0] r_cd, n_cd, cd_dec;
    logic [FLAG_W-1:0]     r_fl, n_fl;

    assign cd_dec  = (r_cd != '0) ? r_cd - TIMER_BITS'(1) : r_cd;
    assign o_flags = r_fl;

    always_comb begin
        n_ph   = r_ph;
        n_last = r_last;
        n_cd   = r_cd;
        n_fl   = r_fl;
        if (i_ctl.tick) begin
            n_cd = cd_dec;
            if (i_ctl.sample) begin
                n_last          = i_ctl.pressed;
                n_fl[FB_HOLD]   = i_ctl.pressed;
                if (i_ctl.pressed && !r_last) n_fl[FB_DOWN] = 1'b1;
                if (!i_ctl.pressed && r_last) n_fl[FB_UP]   = 1'b1;
                case (r_ph)
                    PH_PRESSED: begin
                        if (!i_ctl.pressed) begin
                            n_cd = i_thr.double_ticks;
                            n_ph = PH_RELEASE;
                        end else if (cd_dec == '0) begin
                            n_cd          = i_thr.repeat_ticks;
                            n_fl[FB_LONG] = 1'b1;
                            n_ph          = PH_LONG;
                        end
                    end
                    PH_RELEASE: begin
                        if (i_ctl.pressed) begin
                            n_fl[FB_DOUBLE] = 1'b1;
                            n_ph            = PH_DOUBLE;
                        end else if (cd_dec == '0) begin
                            n_fl[FB_SINGLE] = 1'b1;
                            n_ph            = PH_IDLE;
                        end
                    end
                    PH_DOUBLE: begin
                        if (!i_ctl.pressed) n_ph = PH_IDLE;
                    end
                    PH_LONG: begin
                        if (!i_ctl.pressed) begin
                            n_ph = PH_IDLE;
                        end else if (cd_dec == '0) begin
                            n_cd            = i_thr.repeat_ticks;
                            n_fl[FB_REPEAT] = 1'b1;
                        end
                    end
                    default: begin
                        // idle, and any stray code behaves as idle
                        if (i_ctl.pressed) begin
                            n_cd = i_thr.long_ticks;
                            n_ph = PH_PRESSED;
                        end
                    end
                endcase
            end
        end else if (i_ctl.clr) begin
            n_fl = r_fl & ~i_ctl.clr_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph   <= PH_IDLE;
            r_last <= 1'b0;
            r_cd   <= '0;
            r_fl   <= '0;
        end else begin
            r_ph   <= n_ph;
            r_last <= n_last;
            r_cd   <= n_cd;
            r_fl   <= n_fl;
        end
    end

endmodule

### hdl/multi_key_click_event_detector_top.sv
// Path: an accepted item waits in the input register and moves on into the result register
//   once that register is empty or being read.
// Throughput: one item per cycle. A result waiting in the output register does not
//   stop the next item from entering an empty input register; with both registers
//   full and i_out_ready low the input stalls.
// Reset: synchronous active-low i_rst_n clears all key state, prescaler and valids and
//   loads the register defaults (long 1000, double 200, repeat 100, key count 8).
module multi_key_click_event_detector_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // item input
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  mkced_pkg::t_in_item                   i_in_data,
    // result output
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output mkced_pkg::t_out_item                  o_out_data,
    // configuration writes
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [mkced_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [mkced_pkg::CFG_DAT_W-1:0]       i_cfg_data
);
    import mkced_pkg::*;

    // ---------------------------------------------------------------
    // Configuration registers. Always ready; writes to unknown
    // indexes are accepted and dropped.
    // ---------------------------------------------------------------
    logic [THR_W-1:0]  r_long_ticks, r_double_ticks, r_repeat_ticks;
    logic [KCNT_W-1:0] r_key_count;
    t_thr              thr;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_ticks   <= THR_W'(1000);
            r_double_ticks <= THR_W'(200);
            r_repeat_ticks <= THR_W'(100);
            r_key_count    <= KCNT_W'(8);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_LONG_TICKS:   r_long_ticks   <= i_cfg_data[THR_W-1:0];
                CFG_DOUBLE_TICKS: r_double_ticks <= i_cfg_data[THR_W-1:0];
                CFG_REPEAT_TICKS: r_repeat_ticks <= i_cfg_data[THR_W-1:0];
                CFG_KEY_COUNT:    r_key_count    <= i_cfg_data[KCNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Thresholds are cut (or zero-extended) to the timer width.
    assign thr.long_ticks   = TIMER_BITS'(r_long_ticks);
    assign thr.double_ticks = TIMER_BITS'(r_double_ticks);
    assign thr.repeat_ticks = TIMER_BITS'(r_repeat_ticks);

    // ---------------------------------------------------------------
    // Input register. The item in it is processed (key state updated,
    // result formed) in the cycle it moves into the result register.
    // ---------------------------------------------------------------
    t_in_item r_in;
    logic     r_in_vld;
    logic     r_out_vld;
    logic     adv;

    assign adv        = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // ---------------------------------------------------------------
    // Tick prescaler: every SAMPLE_DIVIDE-th tick also samples pins.
    // Counts on every tick beat, whatever the key count.
    // ---------------------------------------------------------------
    logic [PRESC_W-1:0] r_presc;
    logic               is_tick, is_check, do_sample;

    assign is_tick   = adv && (r_in.action == ACT_TICK);
    assign is_check  = adv && (r_in.action == ACT_CHECK);
    assign do_sample = (r_presc == PRESC_W'(SAMPLE_DIVIDE - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_presc <= '0;
        end else if (is_tick) begin
            r_presc <= do_sample ? '0 : r_presc + PRESC_W'(1);
        end
    end

    // ---------------------------------------------------------------
    // Key lanes. Keys at or above key_count get no ticks or clears and
    // stay frozen. A check reads the selected key's flags (zero when
    // inactive) and clears the matched bits unless the mask is HOLD.
    // ---------------------------------------------------------------
    logic [FLAG_W-1:0] key_fl  [NUM_KEYS];
    logic [NUM_KEYS-1:0] key_sel;
    logic [FLAG_W-1:0] sel_fl;
    logic              hit, clr_ok;

    always_comb begin
        sel_fl = '0;
        for (int k = 0; k < NUM_KEYS; k++) begin
            if (key_sel[k]) sel_fl = sel_fl | key_fl[k];
        end
    end

    assign hit    = (sel_fl & r_in.flag_mask) != '0;
    assign clr_ok = is_check && hit && (r_in.flag_mask != F_HOLD);

    for (genvar g = 0; g < NUM_KEYS; g++) begin : g_key
        logic     act;
        t_key_ctl ctl;

        assign act        = 32'(g) < 32'(r_key_count);
        assign key_sel[g] = act && (32'(r_in.key_index) == 32'(g));

        assign ctl.tick     = is_tick && act;
        assign ctl.sample   = do_sample;
        assign ctl.clr      = clr_ok && key_sel[g];
        assign ctl.clr_mask = r_in.flag_mask;
        if (g < PIN_BITS) begin : g_pin
            assign ctl.pressed = !r_in.pin_levels[g];
        end else begin : g_nopin
            // no pin behind this key: always released
            assign ctl.pressed = 1'b0;
        end

        mkced_key u_key (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_thr   (thr),
            .o_flags (key_fl[g])
        );
    end

    // ---------------------------------------------------------------
    // Result register. Tick beats return zeros.
    // ---------------------------------------------------------------
    t_out_item r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out.event_hit <= is_check && hit;
            r_out.key_flags <= is_check ? sel_fl : '0;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule
